/* design/prgrt_pkg.sv */
package prgrt_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int COLOR_WIDTH = 24;
   localparam int WORLD_WIDTH = 32;
   localparam int CFG_IDX_W = 3;
   localparam int CFG_DATA_W = 32;

   localparam int REQ_DATA_W = ((3 * COORD_WIDTH + COLOR_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W =
      ((1 + 3 * COORD_WIDTH + 3 * WORLD_WIDTH + COLOR_WIDTH + 7) / 8) * 8;

   localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_POS_X = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_POS_Z = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_RIG = 3'd7;

   localparam logic [7:0] RIG_LEGGED_A = 8'd3;
   localparam logic [7:0] RIG_LEGGED_B = 8'd4;

   // Squared range limit of 4 m^2 in (1/4096 m)^2 units.
   localparam int GATE_SHIFT = 26;

   typedef struct packed {
      logic              valid;
      logic [8:0][15:0]  rot;
      logic [2:0][31:0]  trans;
   } xform_type;

   // Divide by 2^14, rounding to nearest with ties away from zero.
   function automatic logic signed [47:0] rnd14(input logic signed [47:0] n);
      logic [47:0] mag;
      logic [47:0] r;
      mag = n[47] ? 48'(-n) : 48'(n);
      r = (mag + 48'd8192) >> 14;
      return n[47] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      if (v > 48'sd32767) return 16'sh7fff;
      if (v < -48'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'sd2147483647) return 32'sh7fffffff;
      if (v < -48'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Lidar-to-camera rotation in units of 1e-5, row major.
   function automatic logic signed [17:0] ext_rot(input logic legged, input logic [3:0] idx);
      if (legged) begin
         case (idx)
            4'd0: return -18'sd1345;
            4'd1: return -18'sd176;
            4'd2: return 18'sd99991;
            4'd3: return 18'sd99991;
            4'd4: return -18'sd176;
            4'd5: return 18'sd1344;
            4'd6: return 18'sd174;
            4'd7: return 18'sd100000;
            4'd8: return 18'sd178;
            default: return 18'sd0;
         endcase
      end else begin
         case (idx)
            4'd0: return -18'sd1181;
            4'd1: return 18'sd53;
            4'd2: return 18'sd99993;
            4'd3: return -18'sd99984;
            4'd4: return 18'sd1322;
            4'd5: return -18'sd1182;
            4'd6: return -18'sd1322;
            4'd7: return -18'sd99991;
            4'd8: return 18'sd38;
            default: return 18'sd0;
         endcase
      end
   endfunction

   // Camera offset plus IMU-to-lidar offset, in units of 1e-5 m.
   function automatic logic signed [17:0] ext_off(input logic legged, input logic [1:0] k);
      if (legged) begin
         case (k)
            2'd0: return 18'sd9187;
            2'd1: return -18'sd6986;
            2'd2: return -18'sd3947;
            default: return 18'sd0;
         endcase
      end else begin
         case (k)
            2'd0: return 18'sd5242;
            2'd1: return 18'sd4740;
            2'd2: return -18'sd14053;
            default: return 18'sd0;
         endcase
      end
   endfunction

endpackage

/* design/prgrt_xform.sv */
module prgrt_xform (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [prgrt_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [prgrt_pkg::CFG_DATA_W-1:0]    csr_wdata,
   output prgrt_pkg::xform_type                xf
);
   import prgrt_pkg::*;

   // Smallest m with floor(n * m / 2^41) == floor(n / 3125) for every n below 2^29.
   localparam logic [29:0] RECIP_3125 = 30'd703687442;

   typedef enum logic [2:0] {ST_MAC, ST_POST, ST_DIV, ST_STORE, ST_READY} state_type;
   typedef enum logic [1:0] {PH_QUAT, PH_ROT, PH_TRANS} phase_type;

   typedef struct packed {
      logic [1:0] ai;
      logic [1:0] bi;
      logic       neg;
   } qsel_type;

   state_type          state_ff;
   phase_type          phase_ff;
   logic [1:0]         row_ff, col_ff, term_ff;
   logic signed [39:0] acc_ff;
   logic [28:0]        num_ff;
   logic [17:0]        quo_ff;
   logic               neg_ff;

   logic signed [15:0] quat_ff [4];
   logic signed [31:0] pos_ff [3];
   logic [7:0]         rig_ff;
   logic signed [15:0] rp_ff [9];
   logic [8:0][15:0]   rot_ff;
   logic [2:0][31:0]   trans_ff;

   // Which quaternion components feed each term of the rotation matrix.
   // Diagonal entries hold the sum of two squares, subtracted from one later.
   function automatic qsel_type qsel(input logic [3:0] ent, input logic term);
      case ({ent, term})
         {4'd0, 1'b0}: return '{2'd2, 2'd2, 1'b0};
         {4'd0, 1'b1}: return '{2'd3, 2'd3, 1'b0};
         {4'd1, 1'b0}: return '{2'd1, 2'd2, 1'b0};
         {4'd1, 1'b1}: return '{2'd0, 2'd3, 1'b1};
         {4'd2, 1'b0}: return '{2'd1, 2'd3, 1'b0};
         {4'd2, 1'b1}: return '{2'd0, 2'd2, 1'b0};
         {4'd3, 1'b0}: return '{2'd1, 2'd2, 1'b0};
         {4'd3, 1'b1}: return '{2'd0, 2'd3, 1'b0};
         {4'd4, 1'b0}: return '{2'd1, 2'd1, 1'b0};
         {4'd4, 1'b1}: return '{2'd3, 2'd3, 1'b0};
         {4'd5, 1'b0}: return '{2'd2, 2'd3, 1'b0};
         {4'd5, 1'b1}: return '{2'd0, 2'd1, 1'b1};
         {4'd6, 1'b0}: return '{2'd1, 2'd3, 1'b0};
         {4'd6, 1'b1}: return '{2'd0, 2'd2, 1'b1};
         {4'd7, 1'b0}: return '{2'd2, 2'd3, 1'b0};
         {4'd7, 1'b1}: return '{2'd0, 2'd1, 1'b0};
         {4'd8, 1'b0}: return '{2'd1, 2'd1, 1'b0};
         {4'd8, 1'b1}: return '{2'd2, 2'd2, 1'b0};
         default:      return '{2'd0, 2'd0, 1'b0};
      endcase
   endfunction

   logic               legged;
   logic [3:0]         ent;
   logic [3:0]         rp_idx;
   logic [3:0]         er_idx;
   qsel_type           qs;
   logic signed [15:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [33:0] prod;
   logic               mul_neg;
   logic               last_term;
   logic               last_ent;
   logic               diag;
   logic signed [47:0] q28;
   logic [39:0]        acc_mag;
   logic [17:0]        half;
   logic [39:0]        rnd_mag;
   logic [28:0]        num_in;
   logic [58:0]        recip_prod;
   logic signed [47:0] quo_s;

   always_comb begin
      legged = (rig_ff == RIG_LEGGED_A) || (rig_ff == RIG_LEGGED_B);
      ent = 4'({row_ff, 1'b0}) + 4'(row_ff) + 4'(col_ff);
      rp_idx = 4'({row_ff, 1'b0}) + 4'(row_ff) + 4'(term_ff);
      er_idx = 4'({term_ff, 1'b0}) + 4'(term_ff) + 4'(col_ff);
      qs = qsel(ent, term_ff[0]);
      case (phase_ff)
         PH_QUAT: begin
            mul_a = quat_ff[qs.ai];
            mul_b = 18'(quat_ff[qs.bi]);
            mul_neg = qs.neg;
         end
         PH_ROT: begin
            mul_a = rp_ff[rp_idx];
            mul_b = ext_rot(legged, er_idx);
            mul_neg = 1'b0;
         end
         default: begin
            mul_a = rp_ff[rp_idx];
            mul_b = ext_off(legged, term_ff);
            mul_neg = 1'b0;
         end
      endcase
      prod = mul_a * mul_b;
      last_term = (phase_ff == PH_QUAT) ? (term_ff == 2'd1) : (term_ff == 2'd2);
      last_ent = (phase_ff == PH_TRANS) ? (row_ff == 2'd2)
                                        : (row_ff == 2'd2 && col_ff == 2'd2);
      diag = (ent == 4'd0) || (ent == 4'd4) || (ent == 4'd8);
      q28 = diag ? (48'sd268435456 - 48'(acc_ff) * 48'sd2) : 48'(acc_ff) * 48'sd2;
      acc_mag = acc_ff[39] ? 40'(-acc_ff) : 40'(acc_ff);
      half = (phase_ff == PH_ROT) ? 18'd50000 : 18'd200000;
      rnd_mag = acc_mag + 40'(half);
      // 100000 is 32 * 3125 and 400000 is 128 * 3125, so the power of two is
      // shifted out first and only a division by 3125 remains.
      num_in = (phase_ff == PH_ROT) ? rnd_mag[33:5] : rnd_mag[35:7];
      recip_prod = 59'(num_ff) * 59'(RECIP_3125);
      quo_s = neg_ff ? -48'(quo_ff) : 48'(quo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MAC;
         phase_ff <= PH_QUAT;
         row_ff <= 2'd0;
         col_ff <= 2'd0;
         term_ff <= 2'd0;
         acc_ff <= '0;
         quat_ff[0] <= 16'sd16384;
         quat_ff[1] <= '0;
         quat_ff[2] <= '0;
         quat_ff[3] <= '0;
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         pos_ff[2] <= '0;
         rig_ff <= 8'd4;
      end else if (csr_we) begin
         // Any register change restarts the rebuild of the cached transform.
         unique case (csr_index)
            REG_QUAT_W: quat_ff[0] <= csr_wdata[15:0];
            REG_QUAT_X: quat_ff[1] <= csr_wdata[15:0];
            REG_QUAT_Y: quat_ff[2] <= csr_wdata[15:0];
            REG_QUAT_Z: quat_ff[3] <= csr_wdata[15:0];
            REG_POS_X:  pos_ff[0] <= csr_wdata;
            REG_POS_Y:  pos_ff[1] <= csr_wdata;
            REG_POS_Z:  pos_ff[2] <= csr_wdata;
            REG_RIG:    rig_ff <= csr_wdata[7:0];
            default:    rig_ff <= rig_ff;
         endcase
         state_ff <= ST_MAC;
         phase_ff <= PH_QUAT;
         row_ff <= 2'd0;
         col_ff <= 2'd0;
         term_ff <= 2'd0;
         acc_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_MAC: begin
               acc_ff <= mul_neg ? acc_ff - 40'(prod) : acc_ff + 40'(prod);
               if (last_term) begin
                  term_ff <= 2'd0;
                  state_ff <= ST_POST;
               end else begin
                  term_ff <= term_ff + 2'd1;
               end
            end
            ST_POST: begin
               if (phase_ff == PH_QUAT) begin
                  rp_ff[ent] <= sat16(rnd14(q28));
                  acc_ff <= '0;
                  state_ff <= ST_MAC;
                  if (last_ent) begin
                     phase_ff <= PH_ROT;
                     row_ff <= 2'd0;
                     col_ff <= 2'd0;
                  end else if (col_ff == 2'd2) begin
                     col_ff <= 2'd0;
                     row_ff <= row_ff + 2'd1;
                  end else begin
                     col_ff <= col_ff + 2'd1;
                  end
               end else begin
                  neg_ff <= acc_ff[39];
                  num_ff <= num_in;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               quo_ff <= recip_prod[58:41];
               state_ff <= ST_STORE;
            end
            ST_STORE: begin
               acc_ff <= '0;
               state_ff <= ST_MAC;
               if (phase_ff == PH_ROT) begin
                  rot_ff[ent] <= sat16(quo_s);
                  if (last_ent) begin
                     phase_ff <= PH_TRANS;
                     row_ff <= 2'd0;
                     col_ff <= 2'd0;
                  end else if (col_ff == 2'd2) begin
                     col_ff <= 2'd0;
                     row_ff <= row_ff + 2'd1;
                  end else begin
                     col_ff <= col_ff + 2'd1;
                  end
               end else begin
                  trans_ff[row_ff] <= sat32(48'(pos_ff[row_ff]) + quo_s);
                  if (last_ent) state_ff <= ST_READY;
                  else row_ff <= row_ff + 2'd1;
               end
            end
            ST_READY: state_ff <= ST_READY;
            default: state_ff <= ST_MAC;
         endcase
      end
   end

   assign xf.valid = (state_ff == ST_READY);
   assign xf.rot = rot_ff;
   assign xf.trans = trans_ff;

endmodule

/* design/point_range_gate_rigid_transform_top.sv */
// Range gate and rigid transform for colored depth points. Each word on req
// yields one word on rsp, and a new point is taken every cycle while nothing
// stalls and the cached transform is ready. Points beyond 2 m are marked not
// kept and get a zero world position; body coordinates, color and tlast
// always pass through. After reset and after every csr write the cached
// pose-times-extrinsic transform is rebuilt by a shared multiply-accumulate
// unit, with the constant divisions done by a shift and a reciprocal multiply.
// It builds the quaternion matrix first, then the nine rotation entries and
// then the three offsets; req_tready stays low until it completes.
module point_range_gate_rigid_transform_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // point_x, point_y, point_z, point_color
   input  logic [prgrt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // kept, body_x, body_y, body_z, world_x, world_y, world_z, out_color
   output logic [prgrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [prgrt_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [prgrt_pkg::CFG_DATA_W-1:0] csr_wdata
);
   import prgrt_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int SQ_W = 2 * CW;
   localparam int DIST_W = SQ_W + 2;
   localparam int PROD_W = CW + 16;
   localparam int SUM_W = CW + 18;

   xform_type xf;

   prgrt_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .xf        (xf)
   );

   logic v1_ff, v2_ff, v3_ff;
   logic adv1, adv2, adv3;

   logic signed [CW-1:0]     px [3];
   logic signed [SQ_W-1:0]   sq_in [3];
   logic signed [PROD_W-1:0] prod_in [9];

   logic [SQ_W-1:0]          sq_ff [3];
   logic signed [PROD_W-1:0] prod_ff [9];
   logic [3*CW-1:0]          body1_ff, body2_ff, body3_ff;
   logic [COLOR_WIDTH-1:0]   color1_ff, color2_ff, color3_ff;
   logic                     last1_ff, last2_ff, last3_ff;

   logic [DIST_W-1:0]        range_sq;
   logic                     kept2_ff, kept3_ff;
   logic signed [SUM_W-1:0]  sum_in [3];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [31:0]       world_in [3];
   logic signed [31:0]       world_ff [3];

   // Each stage refills as soon as the one after it moves on or is empty.
   assign adv3 = !v3_ff || rsp_tready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1 && xf.valid;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         px[i] = req_tdata[i*CW +: CW];
         sq_in[i] = px[i] * px[i];
      end
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[i*3+k] = $signed(xf.rot[i*3+k]) * px[k];
         end
      end
      range_sq = DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = SUM_W'(prod_ff[i*3]) + SUM_W'(prod_ff[i*3+1])
                   + SUM_W'(prod_ff[i*3+2]);
         world_in[i] = kept2_ff ? sat32(rnd14(48'(sum_ff[i]))
                                        + 48'($signed(xf.trans[i]))) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid && req_tready;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         for (int i = 0; i < 3; i++) sq_ff[i] <= sq_in[i];
         for (int j = 0; j < 9; j++) prod_ff[j] <= prod_in[j];
         body1_ff <= req_tdata[3*CW-1:0];
         color1_ff <= req_tdata[3*CW +: COLOR_WIDTH];
         last1_ff <= req_tlast;
      end
      if (adv2) begin
         kept2_ff <= (range_sq <= (DIST_W'(1) << GATE_SHIFT));
         for (int i = 0; i < 3; i++) sum_ff[i] <= sum_in[i];
         body2_ff <= body1_ff;
         color2_ff <= color1_ff;
         last2_ff <= last1_ff;
      end
      if (adv3) begin
         kept3_ff <= kept2_ff;
         for (int i = 0; i < 3; i++) world_ff[i] <= world_in[i];
         body3_ff <= body2_ff;
         color3_ff <= color2_ff;
         last3_ff <= last2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tlast = last3_ff;
   assign rsp_tdata = RSP_DATA_W'({color3_ff, world_ff[2], world_ff[1], world_ff[0],
                                   body3_ff, kept3_ff});

`ifndef NO_ASSERTIONS
   a_accept_needs_xform: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> xf.valid)
      else $error("point accepted while the transform was being rebuilt");

   a_csr_invalidates: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !xf.valid)
      else $error("register write did not invalidate the cached transform");

   a_dropped_world_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !kept3_ff |-> world_ff[0] == 0 && world_ff[1] == 0
                                  && world_ff[2] == 0)
      else $error("dropped point carries a nonzero world position");
`endif

endmodule
